// ----- sv/wrsp_pkg.sv -----
`timescale 1ns / 1ps

package wrsp_pkg;

    // parser phase
    typedef enum logic [2:0] {
        PH_ID        = 3'd0,
        PH_LEN       = 3'd1,
        PH_SKIP      = 3'd2,
        PH_FIXED     = 3'd3,
        PH_PSUITES   = 3'd4,
        PH_ACOUNT_LO = 3'd5,
        PH_ACOUNT_HI = 3'd6,
        PH_ASUITES   = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        CLASS_NONE = 2'd0,
        CLASS_WPA  = 2'd1,
        CLASS_RSN  = 2'd2
    } elem_class_t;

    typedef enum logic [1:0] {
        KIND_GROUP    = 2'd0,
        KIND_PAIRWISE = 2'd1,
        KIND_AKM      = 2'd2
    } list_kind_t;

    localparam logic [7:0]  ID_RSN      = 8'h30;
    localparam logic [7:0]  ID_VENDOR   = 8'hdd;
    localparam logic [23:0] RSN_OUI     = 24'h000fac;
    localparam logic [23:0] WPA_OUI     = 24'h0050f2;
    localparam logic [7:0]  WPA_TYPE    = 8'h01;

    localparam logic [2:0]  CODE_NONE   = 3'd0;  // suite code on an empty list
    localparam logic [2:0]  CODE_TKIP   = 3'd2;
    localparam logic [2:0]  CODE_PROP   = 3'd6;
    localparam logic [2:0]  CODE_UNK    = 3'd7;
    localparam logic [7:0]  CIPHER_LIM  = 8'd6;
    localparam logic [7:0]  AKM_LIM     = 8'd3;

    localparam int          RES_DEPTH   = 4;
    localparam int          RES_AW      = $clog2(RES_DEPTH);

    typedef struct packed {
        logic       security_flavor;
        list_kind_t list_kind;
        logic [2:0] suite_code;
        logic [5:0] list_index;
        logic       defaulted;
        logic       empty_list;
        logic       last_in_list;
    } result_t;

    // up to two results per input byte, first one in slot 0
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } res_pair_t;

endpackage

// ----- sv/wrsp_core.sv -----
`timescale 1ns / 1ps

module wrsp_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 consume,
    input  logic [7:0]           ie_byte,
    input  logic                 buffer_end,
    output wrsp_pkg::res_pair_t  res
);

    wrsp_pkg::phase_t      phase_reg, phase_next;
    wrsp_pkg::elem_class_t class_reg, class_next;
    logic [7:0]            len_reg, len_next;
    logic [7:0]            pos_reg, pos_next;
    logic [23:0]           sbytes_reg, sbytes_next;
    logic [15:0]           count_reg, count_next;
    logic [5:0]            spos_reg, spos_next;

    function automatic logic [2:0] suite_code_of(
        input wrsp_pkg::elem_class_t cls,
        input logic [23:0]           sb,
        input logic [7:0]            stype,
        input logic [7:0]            limit
    );
        logic [23:0] want;
        begin
            want = (cls == wrsp_pkg::CLASS_RSN) ? wrsp_pkg::RSN_OUI : wrsp_pkg::WPA_OUI;
            if (sb != want)
                suite_code_of = wrsp_pkg::CODE_PROP;
            else if (stype < limit)
                suite_code_of = stype[2:0];
            else
                suite_code_of = wrsp_pkg::CODE_UNK;
        end
    endfunction

    function automatic wrsp_pkg::result_t mk_res(
        input logic                 flavor,
        input wrsp_pkg::list_kind_t kind,
        input logic [2:0]           code,
        input logic [5:0]           idx,
        input logic                 dflt,
        input logic                 empty,
        input logic                 last
    );
        wrsp_pkg::result_t r;
        begin
            r.security_flavor = flavor;
            r.list_kind       = kind;
            r.suite_code      = code;
            r.list_index      = idx;
            r.defaulted       = dflt;
            r.empty_list      = empty;
            r.last_in_list    = last;
            mk_res = r;
        end
    endfunction

    logic                  flavor;
    logic                  body;
    logic [8:0]            hdr;
    logic [8:0]            p9;
    logic [8:0]            len9;
    logic [15:0]           cnt;
    logic [18:0]           need;
    logic                  last;
    wrsp_pkg::elem_class_t cls;

    assign flavor = (class_reg == wrsp_pkg::CLASS_RSN);
    assign p9     = {1'b0, pos_reg};
    assign len9   = {1'b0, len_reg};
    assign hdr    = (class_reg == wrsp_pkg::CLASS_WPA) ? 9'd4 : 9'd0;

    always_comb
    begin
        phase_next  = phase_reg;
        class_next  = class_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        sbytes_next = sbytes_reg;
        count_next  = count_reg;
        spos_next   = spos_reg;
        res         = '0;
        body        = 1'b1;
        cls         = class_reg;
        cnt         = count_reg | {ie_byte, 8'h00};
        need        = '0;
        last        = ({11'd0, spos_reg} + 17'd1) >= {1'b0, count_reg};

        case (phase_reg)
            wrsp_pkg::PH_ID:
            begin
                body = 1'b0;
                if (ie_byte == wrsp_pkg::ID_RSN)
                    class_next = wrsp_pkg::CLASS_RSN;
                else if (ie_byte == wrsp_pkg::ID_VENDOR)
                    class_next = wrsp_pkg::CLASS_WPA;
                else
                    class_next = wrsp_pkg::CLASS_NONE;
                phase_next = wrsp_pkg::PH_LEN;
            end
            wrsp_pkg::PH_LEN:
            begin
                body        = 1'b0;
                len_next    = ie_byte;
                pos_next    = '0;
                sbytes_next = '0;
                count_next  = '0;
                spos_next   = '0;
                if (ie_byte == 8'd0)
                begin
                    phase_next = wrsp_pkg::PH_ID;
                end
                else
                begin
                    if ((class_reg == wrsp_pkg::CLASS_RSN && ie_byte < 8'd2) ||
                        (class_reg == wrsp_pkg::CLASS_WPA && ie_byte < 8'd6))
                        cls = wrsp_pkg::CLASS_NONE;
                    class_next = cls;
                    phase_next = (cls == wrsp_pkg::CLASS_NONE) ? wrsp_pkg::PH_SKIP
                                                               : wrsp_pkg::PH_FIXED;
                end
            end
            wrsp_pkg::PH_SKIP:
            begin
                body = 1'b1;
            end
            wrsp_pkg::PH_FIXED:
            begin
                if (class_reg == wrsp_pkg::CLASS_WPA && pos_reg < 8'd4)
                begin
                    // vendor OUI and type check
                    if (pos_reg < 8'd3)
                        sbytes_next = {sbytes_reg[15:0], ie_byte};
                    else if (sbytes_reg != wrsp_pkg::WPA_OUI || ie_byte != wrsp_pkg::WPA_TYPE)
                    begin
                        class_next = wrsp_pkg::CLASS_NONE;
                        phase_next = wrsp_pkg::PH_SKIP;
                    end
                end
                else if (p9 >= hdr + 9'd2 && p9 <= hdr + 9'd4)
                begin
                    sbytes_next = {sbytes_reg[15:0], ie_byte};
                end
                else if (p9 == hdr + 9'd5)
                begin
                    res.v0 = 1'b1;
                    res.r0 = mk_res(flavor, wrsp_pkg::KIND_GROUP,
                                    suite_code_of(class_reg, sbytes_reg, ie_byte,
                                                  wrsp_pkg::CIPHER_LIM),
                                    6'd0, 1'b0, 1'b0, 1'b1);
                    if (len9 < hdr + 9'd8)
                    begin
                        // no room for a pairwise count
                        res.v1     = 1'b1;
                        res.r1     = mk_res(flavor, wrsp_pkg::KIND_PAIRWISE,
                                            wrsp_pkg::CODE_TKIP, 6'd0, 1'b1, 1'b0, 1'b1);
                        phase_next = wrsp_pkg::PH_SKIP;
                    end
                end
                else if (p9 == hdr + 9'd6)
                begin
                    count_next = {8'h00, ie_byte};
                end
                else if (p9 == hdr + 9'd7)
                begin
                    count_next = cnt;
                    need       = {10'd0, hdr} + 19'd8 + {1'b0, cnt, 2'b00};
                    if ({11'd0, len_reg} < need)
                        phase_next = wrsp_pkg::PH_SKIP;
                    else if (cnt == 16'd0)
                    begin
                        res.v0     = 1'b1;
                        res.r0     = mk_res(flavor, wrsp_pkg::KIND_PAIRWISE,
                                            wrsp_pkg::CODE_NONE,
                                            6'd0, 1'b0, 1'b1, 1'b1);
                        phase_next = (len9 < p9 + 9'd3) ? wrsp_pkg::PH_SKIP
                                                        : wrsp_pkg::PH_ACOUNT_LO;
                    end
                    else
                    begin
                        spos_next  = '0;
                        phase_next = wrsp_pkg::PH_PSUITES;
                    end
                end
                // short element: TKIP defaults on its last byte
                if (phase_next == wrsp_pkg::PH_FIXED && len9 < hdr + 9'd6 &&
                    p9 + 9'd1 == len9)
                begin
                    res.v0 = 1'b1;
                    res.r0 = mk_res(flavor, wrsp_pkg::KIND_GROUP, wrsp_pkg::CODE_TKIP,
                                    6'd0, 1'b1, 1'b0, 1'b1);
                    res.v1 = 1'b1;
                    res.r1 = mk_res(flavor, wrsp_pkg::KIND_PAIRWISE, wrsp_pkg::CODE_TKIP,
                                    6'd0, 1'b1, 1'b0, 1'b1);
                end
            end
            wrsp_pkg::PH_PSUITES:
            begin
                if (pos_reg[1:0] != 2'd3)
                    sbytes_next = {sbytes_reg[15:0], ie_byte};
                else
                begin
                    res.v0    = 1'b1;
                    res.r0    = mk_res(flavor, wrsp_pkg::KIND_PAIRWISE,
                                       suite_code_of(class_reg, sbytes_reg, ie_byte,
                                                     wrsp_pkg::CIPHER_LIM),
                                       spos_reg, 1'b0, 1'b0, last);
                    spos_next = spos_reg + 6'd1;
                    if (last)
                        phase_next = (len9 < p9 + 9'd3) ? wrsp_pkg::PH_SKIP
                                                        : wrsp_pkg::PH_ACOUNT_LO;
                end
            end
            wrsp_pkg::PH_ACOUNT_LO:
            begin
                count_next = {8'h00, ie_byte};
                phase_next = wrsp_pkg::PH_ACOUNT_HI;
            end
            wrsp_pkg::PH_ACOUNT_HI:
            begin
                count_next = cnt;
                need       = {11'd0, pos_reg} + 19'd1 + {1'b0, cnt, 2'b00};
                if ({11'd0, len_reg} < need)
                    phase_next = wrsp_pkg::PH_SKIP;
                else if (cnt == 16'd0)
                begin
                    res.v0     = 1'b1;
                    res.r0     = mk_res(flavor, wrsp_pkg::KIND_AKM, wrsp_pkg::CODE_NONE,
                                        6'd0, 1'b0, 1'b1, 1'b1);
                    phase_next = wrsp_pkg::PH_SKIP;
                end
                else
                begin
                    spos_next  = '0;
                    phase_next = wrsp_pkg::PH_ASUITES;
                end
            end
            wrsp_pkg::PH_ASUITES:
            begin
                // AKM suites sit two bytes off the 4-byte grid
                if (pos_reg[1:0] != 2'd1)
                    sbytes_next = {sbytes_reg[15:0], ie_byte};
                else
                begin
                    res.v0    = 1'b1;
                    res.r0    = mk_res(flavor, wrsp_pkg::KIND_AKM,
                                       suite_code_of(class_reg, sbytes_reg, ie_byte,
                                                     wrsp_pkg::AKM_LIM),
                                       spos_reg, 1'b0, 1'b0, last);
                    spos_next = spos_reg + 6'd1;
                    if (last)
                        phase_next = wrsp_pkg::PH_SKIP;
                end
            end
            default:
            begin
                body       = 1'b0;
                phase_next = wrsp_pkg::PH_ID;
            end
        endcase

        if (body)
        begin
            pos_next = pos_reg + 8'd1;
            if (p9 + 9'd1 >= len9)
                phase_next = wrsp_pkg::PH_ID;
        end
        if (buffer_end)
            phase_next = wrsp_pkg::PH_ID;

        if (!consume)
            res = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wrsp_pkg::PH_ID;
            class_reg  <= wrsp_pkg::CLASS_NONE;
            len_reg    <= '0;
            pos_reg    <= '0;
            sbytes_reg <= '0;
            count_reg  <= '0;
            spos_reg   <= '0;
        end
        else if (consume)
        begin
            phase_reg  <= phase_next;
            class_reg  <= class_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            sbytes_reg <= sbytes_next;
            count_reg  <= count_next;
            spos_reg   <= spos_next;
        end
    end

endmodule

// ----- sv/wrsp_res_fifo.sv -----
`timescale 1ns / 1ps

module wrsp_res_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  wrsp_pkg::res_pair_t  res,
    input  logic                 pop,
    output logic                 not_empty,
    output logic                 room2,
    output wrsp_pkg::result_t    head
);

    localparam int AW = wrsp_pkg::RES_AW;

    wrsp_pkg::result_t mem_reg [wrsp_pkg::RES_DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW:0]       cnt_reg, cnt_next;
    logic [AW-1:0]     wr_ptr1;
    logic              do_pop;

    assign not_empty = (cnt_reg != '0);
    assign room2     = (cnt_reg <= (AW+1)'(wrsp_pkg::RES_DEPTH - 2));
    assign head      = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;
    assign wr_ptr1   = wr_ptr_reg + AW'(res.v0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(res.v0) + AW'(res.v1);
        rd_ptr_next = rd_ptr_reg + AW'(do_pop);
        cnt_next    = cnt_reg + (AW+1)'(res.v0) + (AW+1)'(res.v1) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (res.v0)
            mem_reg[wr_ptr_reg] <= res.r0;
        if (res.v1)
            mem_reg[wr_ptr1] <= res.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- sv/wpa_rsn_ie_suite_parser.sv -----
`timescale 1ns / 1ps

// Channel  | Dir | tdata (low bit up)                          | tuser / tlast
// ---------+-----+---------------------------------------------+--------------------------
// s_axis   | in  | [7:0] ie_byte                               | tlast = buffer_end
// m_axis   | out | [2:0] suite_code, [8:3] list_index,         | tuser [0] security_flavor,
//          |     | [9] defaulted, [10] empty_list, rest zero   | [2:1] list_kind;
//          |     |                                             | tlast = last_in_list
//
// One byte is taken every cycle unless the input stalls. Each byte sits in the input
// register while the parser core updates its state and emits up to two suites. Suites
// go into a four-entry result queue and leave one per cycle while m_axis_tready is high;
// a result passes the input register and then the queue. A short element, or one with no
// room for a pairwise count, yields two results from one byte, and the input stalls just
// while the queue has fewer than two free slots. Reset (rst_n low, asynchronous) empties
// the input register and the queue and puts the parser back to waiting for an element id.

module wpa_rsn_ie_suite_parser
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ie_byte
    input  logic        s_axis_tlast,   // buffer_end

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] suite_code, [8:3] list_index,
                                        // [9] defaulted, [10] empty_list
    output logic [2:0]  m_axis_tuser,   // [0] security_flavor, [2:1] list_kind
    output logic        m_axis_tlast    // last_in_list
);

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              in_end_reg;

    logic              consume;
    logic              room2;
    logic              fifo_not_empty;
    logic              s_accept;
    wrsp_pkg::res_pair_t res;
    wrsp_pkg::result_t   head;

    // a byte is processed only when the queue can absorb two results
    assign consume       = in_valid_reg && room2;
    assign s_axis_tready = !in_valid_reg || consume;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (s_accept)
            in_valid_next = 1'b1;
        else if (consume)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tlast;
        end
    end

    wrsp_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .consume    (consume),
        .ie_byte    (in_byte_reg),
        .buffer_end (in_end_reg),
        .res        (res)
    );

    wrsp_res_fifo u_res_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .res        (res),
        .pop        (m_axis_tready),
        .not_empty  (fifo_not_empty),
        .room2      (room2),
        .head       (head)
    );

    assign m_axis_tvalid = fifo_not_empty;
    assign m_axis_tdata  = {5'd0, head.empty_list, head.defaulted,
                            head.list_index, head.suite_code};
    assign m_axis_tuser  = {head.list_kind, head.security_flavor};
    assign m_axis_tlast  = head.last_in_list;

endmodule
